// ===== rtl/mpid_pkg.sv =====
// Shared types, constants and width helpers for the motor position PID step.
package mpid_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF = 24;
    localparam int TARGET_W        = 24;
    localparam int GAIN_W          = 24;
    localparam int LIMIT_W         = 23;
    localparam int DUTY_W          = 8;
    localparam int SUM_W           = 32;
    localparam int ANGLE_SHIFT     = 8;
    localparam int ROUND_BIAS      = 128;
    localparam int U_FRAC          = 32;
    localparam int CFG_ADDR_W      = 5;
    localparam int CFG_DATA_W      = 32;

    typedef enum logic [2:0] {
        REG_ANGLE_PER_COUNT   = 3'd0,
        REG_PROPORTIONAL_GAIN = 3'd1,
        REG_DERIVATIVE_GAIN   = 3'd2,
        REG_INTEGRAL_GAIN     = 3'd3,
        REG_DEADBAND          = 3'd4,
        REG_INTEGRATE_LIMIT   = 3'd5,
        REG_MINIMUM_DUTY      = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  angle_per_count;
        logic [GAIN_W-1:0]  proportional_gain;
        logic [GAIN_W-1:0]  derivative_gain;
        logic [GAIN_W-1:0]  integral_gain;
        logic [LIMIT_W-1:0] deadband;
        logic [LIMIT_W-1:0] integrate_limit;
        logic [DUTY_W-1:0]  minimum_duty;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        angle_per_count:   24'd47783,
        proportional_gain: 24'd5711216,
        derivative_gain:   24'd2854912,
        integral_gain:     24'd20890,
        deadband:          23'd1311,
        integrate_limit:   23'd13107,
        minimum_duty:      8'd20
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANGLE,
        S_ERR,
        S_MAG,
        S_COND,
        S_MULP,
        S_MULD,
        S_MULI,
        S_UMAG,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MSEL_ANGLE,
        MSEL_P,
        MSEL_D,
        MSEL_I
    } mul_sel_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic step;
        logic rnd;
    } mac_ctl_t;

    typedef struct packed {
        logic calc_err;
        logic calc_mag;
        logic calc_cond;
    } err_ctl_t;

    typedef struct packed {
        logic saturated;
        logic integrating;
        logic in_deadband;
    } err_flags_t;

    // error width: target minus angle, one bit of growth
    function automatic int err_width(input int aw);
        return ((aw > TARGET_W) ? aw : TARGET_W) + 1;
    endfunction

    // accumulator width: holds every product and the sum of the three terms
    function automatic int acc_width(input int aw);
        int ew;
        ew = err_width(aw);
        return GAIN_W + (((ew + 1) > SUM_W) ? (ew + 1) : SUM_W) + 2;
    endfunction

endpackage

// ===== rtl/mpid_if.sv =====
// Valid/ready channel interfaces for the PID step requests and results.
interface mpid_in_if #(
    parameter int COUNT_WIDTH = mpid_pkg::COUNT_WIDTH_DEF
);
    import mpid_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COUNT_WIDTH-1:0] encoder_count;
    logic signed [TARGET_W-1:0]    target_angle;
    logic                          target_changed;

    modport source (
        output valid, encoder_count, target_angle, target_changed,
        input  ready
    );
    modport sink (
        input  valid, encoder_count, target_angle, target_changed,
        output ready
    );
endinterface

interface mpid_out_if #(
    parameter int ANGLE_WIDTH = mpid_pkg::ANGLE_WIDTH_DEF
);
    import mpid_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [DUTY_W-1:0]             duty;
    logic                          direction;
    logic signed [ANGLE_WIDTH-1:0] position_angle;
    logic                          integrating;
    logic                          saturated;

    modport source (
        output valid, duty, direction, position_angle, integrating, saturated,
        input  ready
    );
    modport sink (
        input  valid, duty, direction, position_angle, integrating, saturated,
        output ready
    );
endinterface

// ===== rtl/mpid_cfg.sv =====
// APB-style configuration register file for the PID step.
module mpid_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpid_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mpid_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mpid_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output mpid_pkg::cfg_t                  cfg
);
    import mpid_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_ANGLE_PER_COUNT:   cfg_reg.angle_per_count   <= pwdata[GAIN_W-1:0];
                REG_PROPORTIONAL_GAIN: cfg_reg.proportional_gain <= pwdata[GAIN_W-1:0];
                REG_DERIVATIVE_GAIN:   cfg_reg.derivative_gain   <= pwdata[GAIN_W-1:0];
                REG_INTEGRAL_GAIN:     cfg_reg.integral_gain     <= pwdata[GAIN_W-1:0];
                REG_DEADBAND:          cfg_reg.deadband          <= pwdata[LIMIT_W-1:0];
                REG_INTEGRATE_LIMIT:   cfg_reg.integrate_limit   <= pwdata[LIMIT_W-1:0];
                REG_MINIMUM_DUTY:      cfg_reg.minimum_duty      <= pwdata[DUTY_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ANGLE_PER_COUNT:   prdata = CFG_DATA_W'(cfg_reg.angle_per_count);
            REG_PROPORTIONAL_GAIN: prdata = CFG_DATA_W'(cfg_reg.proportional_gain);
            REG_DERIVATIVE_GAIN:   prdata = CFG_DATA_W'(cfg_reg.derivative_gain);
            REG_INTEGRAL_GAIN:     prdata = CFG_DATA_W'(cfg_reg.integral_gain);
            REG_DEADBAND:          prdata = CFG_DATA_W'(cfg_reg.deadband);
            REG_INTEGRATE_LIMIT:   prdata = CFG_DATA_W'(cfg_reg.integrate_limit);
            REG_MINIMUM_DUTY:      prdata = CFG_DATA_W'(cfg_reg.minimum_duty);
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== rtl/mpid_mac.sv =====
// Bit-serial multiply-accumulate: one multiplier bit per cycle, serial sum register.
module mpid_mac #(
    parameter int UW = mpid_pkg::acc_width(mpid_pkg::ANGLE_WIDTH_DEF)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mpid_pkg::mac_ctl_t          ctl,
    input  logic [mpid_pkg::GAIN_W-1:0] mcand,
    input  logic [UW-1:0]               mplier,
    output logic [UW-1:0]               acc_sum
);
    import mpid_pkg::*;

    logic [GAIN_W-1:0] a_reg;
    logic [GAIN_W-1:0] part_reg;
    logic [UW-1:0]     op_reg;
    logic [UW-1:0]     sum_reg;
    logic              carry_reg;

    logic [GAIN_W:0]   part_next;
    logic [1:0]        bit_add;

    // partial product plus the selected multiplicand; the low bit leaves serially
    assign part_next = {1'b0, part_reg} + (op_reg[0] ? {1'b0, a_reg} : '0);
    assign bit_add   = {1'b0, sum_reg[0]} + {1'b0, part_next[0]} + {1'b0, carry_reg};
    assign acc_sum   = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            carry_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            carry_reg <= bit_add[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg    <= mcand;
            part_reg <= ctl.rnd ? GAIN_W'(ROUND_BIAS) : '0;
            op_reg   <= mplier;
        end
        else if (ctl.step)
        begin
            part_reg <= part_next[GAIN_W:1];
            // sign bits keep feeding in above the operand width
            op_reg   <= {op_reg[UW-1], op_reg[UW-1:1]};
        end

        if (ctl.step)
        begin
            sum_reg <= {bit_add[0], sum_reg[UW-1:1]};
        end
        else if (ctl.clear)
        begin
            sum_reg <= '0;
        end
    end

endmodule

// ===== rtl/mpid_err.sv =====
// Angle saturation, error, conditional integrator and controller state.
module mpid_err #(
    parameter int ANGLE_WIDTH = mpid_pkg::ANGLE_WIDTH_DEF,
    parameter int UW          = mpid_pkg::acc_width(mpid_pkg::ANGLE_WIDTH_DEF)
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  mpid_pkg::err_ctl_t                          ctl,
    input  logic [UW-1:0]                               prod,
    input  logic signed [mpid_pkg::TARGET_W-1:0]        target,
    input  logic                                        changed,
    input  logic [mpid_pkg::LIMIT_W-1:0]                deadband,
    input  logic [mpid_pkg::LIMIT_W-1:0]                integrate_limit,
    output logic signed [ANGLE_WIDTH-1:0]               angle,
    output logic signed [mpid_pkg::err_width(ANGLE_WIDTH)-1:0]   err,
    output logic signed [mpid_pkg::err_width(ANGLE_WIDTH):0]     diff,
    output logic signed [mpid_pkg::SUM_W-1:0]           esum,
    output mpid_pkg::err_flags_t                        flags
);
    import mpid_pkg::*;

    localparam int EW = err_width(ANGLE_WIDTH);
    localparam int DW = EW + 1;
    localparam int SW = ((EW > SUM_W) ? EW : SUM_W) + 1;
    localparam int LO = ANGLE_WIDTH + ANGLE_SHIFT - 1;
    localparam int HW = UW - LO;
    localparam logic signed [ANGLE_WIDTH-1:0] AMAX = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
    localparam logic signed [ANGLE_WIDTH-1:0] AMIN = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
    localparam logic signed [SW-1:0] SMAX = {{(SW-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

    logic signed [ANGLE_WIDTH-1:0] angle_reg;
    logic signed [EW-1:0]          err_reg;
    logic [EW-1:0]                 aerr_reg;
    logic signed [DW-1:0]          diff_reg;
    logic signed [EW-1:0]          prev_reg;
    logic signed [SUM_W-1:0]       esum_reg;
    err_flags_t                    flags_reg;

    logic [HW-1:0]                 hi_bits;
    logic                          fits;
    logic signed [ANGLE_WIDTH-1:0] angle_sat;
    logic signed [EW-1:0]          err_calc;
    logic                          above_db;
    logic                          below_lim;
    logic                          in_win;
    logic signed [SUM_W-1:0]       sum_base;
    logic signed [SW-1:0]          sum_calc;
    logic                          sum_hi;
    logic                          sum_lo;
    logic signed [SUM_W-1:0]       sum_sat;

    // floor shift of the rounded product, then clamp to the angle range
    assign hi_bits   = prod[UW-1:LO];
    assign fits      = (hi_bits == '0) || (hi_bits == '1);
    assign angle_sat = fits ? prod[LO:ANGLE_SHIFT] : (prod[UW-1] ? AMIN : AMAX);
    assign err_calc  = EW'(target) - EW'(angle_sat);

    assign above_db  = aerr_reg > EW'(deadband);
    assign below_lim = aerr_reg < EW'(integrate_limit);
    assign in_win    = above_db && below_lim;
    assign sum_base  = changed ? '0 : esum_reg;
    assign sum_calc  = SW'(sum_base) + SW'(err_reg);
    assign sum_hi    = sum_calc > SMAX;
    assign sum_lo    = sum_calc < SMIN;
    assign sum_sat   = sum_hi ? SMAX[SUM_W-1:0] :
                       (sum_lo ? SMIN[SUM_W-1:0] : sum_calc[SUM_W-1:0]);

    assign angle = angle_reg;
    assign err   = err_reg;
    assign diff  = diff_reg;
    assign esum  = esum_reg;
    assign flags = flags_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.calc_err)
        begin
            angle_reg <= angle_sat;
            err_reg   <= err_calc;
        end
        if (ctl.calc_mag)
        begin
            aerr_reg <= err_reg[EW-1] ? (~err_reg + 1'b1) : err_reg;
            diff_reg <= DW'(err_reg) - DW'(prev_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            esum_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            if (ctl.calc_err)
            begin
                flags_reg.saturated <= !fits;
            end
            if (ctl.calc_cond)
            begin
                prev_reg                <= err_reg;
                // outside the window the sum drops to zero
                esum_reg                <= in_win ? sum_sat : '0;
                flags_reg.integrating   <= in_win;
                flags_reg.in_deadband   <= !above_db;
                flags_reg.saturated     <= flags_reg.saturated | (in_win & (sum_hi | sum_lo));
            end
        end
    end

endmodule

// ===== rtl/motor_position_pid_step.sv =====
// Top level of the motor position PID step: sequencer, serial datapath and result register.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid / ready        encoder_count, target_angle, target_changed
//  out_ch    out  valid / ready        duty, direction, position_angle, integrating,
//                                      saturated
//  apb       in   psel/penable/pwrite  paddr, pwdata -> prdata, pready tied high
//
//  A request runs the angle multiply, the error, magnitude and integrator steps, the P, D
//  and I products and the output magnitude (UW = 58 at the default widths). The next
//  request is taken only once this result is loaded into the output register: the single
//  bit-serial multiplier takes one multiplier bit per cycle for the angle scale and for each of the three gain terms.
//  Reset clears the sequencer, the previous error and the error sum and loads register
//  defaults. A new request is taken while an earlier result still waits on out_ch; a
//  finished result holds until out_ch is free.
module motor_position_pid_step #(
    parameter int COUNT_WIDTH = mpid_pkg::COUNT_WIDTH_DEF,
    parameter int ANGLE_WIDTH = mpid_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpid_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mpid_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mpid_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    mpid_in_if.sink                         in_ch,
    mpid_out_if.source                      out_ch
);
    import mpid_pkg::*;

    localparam int EW   = err_width(ANGLE_WIDTH);
    localparam int DW   = EW + 1;
    localparam int UW   = acc_width(ANGLE_WIDTH);
    localparam int CNTW = $clog2(UW);
    localparam int HIW  = UW - U_FRAC;
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(UW - 1);

    cfg_t       cfg;
    mac_ctl_t   mac_ctl;
    err_ctl_t   err_ctl;
    err_flags_t err_flags;
    mul_sel_t   mul_sel;

    state_t     state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    logic signed [TARGET_W-1:0]    target_reg;
    logic                          changed_reg;
    logic                          dir_reg;
    logic [HIW-1:0]                hi_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]             duty_reg;
    logic                          direction_reg;
    logic signed [ANGLE_WIDTH-1:0] angle_out_reg;
    logic                          integ_out_reg;
    logic                          sat_out_reg;

    logic                          take_in;
    logic                          umag_en;
    logic                          out_load;
    logic [GAIN_W-1:0]             mcand;
    logic [UW-1:0]                 mplier;
    logic [UW-1:0]                 acc_sum;
    logic [UW-1:0]                 u_mag;
    logic signed [ANGLE_WIDTH-1:0] angle_val;
    logic signed [EW-1:0]          err_val;
    logic signed [DW-1:0]          diff_val;
    logic signed [SUM_W-1:0]       err_sum;
    logic [DUTY_W-1:0]             duty_clamp;
    logic [DUTY_W-1:0]             duty_floor;
    logic [DUTY_W-1:0]             duty_fin;

    mpid_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mpid_mac #(
        .UW (UW)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .mcand   (mcand),
        .mplier  (mplier),
        .acc_sum (acc_sum)
    );

    mpid_err #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .UW          (UW)
    ) u_err (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (err_ctl),
        .prod            (acc_sum),
        .target          (target_reg),
        .changed         (changed_reg),
        .deadband        (cfg.deadband),
        .integrate_limit (cfg.integrate_limit),
        .angle           (angle_val),
        .err             (err_val),
        .diff            (diff_val),
        .esum            (err_sum),
        .flags           (err_flags)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        case (mul_sel)
            MSEL_ANGLE:
            begin
                mcand  = cfg.angle_per_count;
                mplier = UW'($signed(in_ch.encoder_count[COUNT_WIDTH-1:0]));
            end
            MSEL_P:
            begin
                mcand  = cfg.proportional_gain;
                mplier = UW'(err_val);
            end
            MSEL_D:
            begin
                mcand  = cfg.derivative_gain;
                mplier = UW'(diff_val);
            end
            MSEL_I:
            begin
                mcand  = cfg.integral_gain;
                mplier = UW'(err_sum);
            end
            default:
            begin
                mcand  = '0;
                mplier = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mac_ctl    = '0;
        err_ctl    = '0;
        mul_sel    = MSEL_ANGLE;
        take_in    = 1'b0;
        umag_en    = 1'b0;
        out_load   = 1'b0;
        in_ch.ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    take_in       = 1'b1;
                    mac_ctl.load  = 1'b1;
                    mac_ctl.clear = 1'b1;
                    mac_ctl.rnd   = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                mac_ctl.step = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ERR:
            begin
                err_ctl.calc_err = 1'b1;
                state_next       = S_MAG;
            end
            S_MAG:
            begin
                err_ctl.calc_mag = 1'b1;
                state_next       = S_COND;
            end
            S_COND:
            begin
                err_ctl.calc_cond = 1'b1;
                mul_sel           = MSEL_P;
                mac_ctl.load      = 1'b1;
                mac_ctl.clear     = 1'b1;
                cnt_next          = '0;
                state_next        = S_MULP;
            end
            S_MULP:
            begin
                mac_ctl.step = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    mul_sel      = MSEL_D;
                    mac_ctl.load = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_MULD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MULD:
            begin
                mac_ctl.step = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    mul_sel      = MSEL_I;
                    mac_ctl.load = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_MULI;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MULI:
            begin
                mac_ctl.step = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_UMAG;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_UMAG:
            begin
                umag_en    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign u_mag      = acc_sum[UW-1] ? (~acc_sum + 1'b1) : acc_sum;
    assign duty_clamp = (|hi_reg[HIW-1:DUTY_W]) ? {DUTY_W{1'b1}} : hi_reg[DUTY_W-1:0];
    assign duty_floor = ((duty_clamp != '0) && (duty_clamp < cfg.minimum_duty)) ?
                        cfg.minimum_duty : duty_clamp;
    assign duty_fin   = err_flags.in_deadband ? '0 : duty_floor;

    assign out_valid_next = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            target_reg  <= in_ch.target_angle;
            changed_reg <= in_ch.target_changed;
        end
        if (umag_en)
        begin
            dir_reg <= acc_sum[UW-1];
            hi_reg  <= u_mag[UW-1:U_FRAC];
        end
        if (out_load)
        begin
            duty_reg      <= duty_fin;
            direction_reg <= dir_reg;
            angle_out_reg <= angle_val;
            integ_out_reg <= err_flags.integrating;
            sat_out_reg   <= err_flags.saturated;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.duty           = duty_reg;
    assign out_ch.direction      = direction_reg;
    assign out_ch.position_angle = angle_out_reg;
    assign out_ch.integrating    = integ_out_reg;
    assign out_ch.saturated      = sat_out_reg;

`ifndef SYNTHESIS
    a_accept_starts_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg == S_ANGLE && cnt_reg == '0))
        else $error("request did not start the angle multiply");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the completion state");

    a_sum_cleared_outside_window: assert property (@(posedge clk) disable iff (!rst_n)
        err_ctl.calc_cond |=> (err_flags.integrating || err_sum == '0))
        else $error("error sum kept while not integrating");

    a_duty_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.duty == '0 || out_ch.duty >= cfg.minimum_duty))
        else $error("nonzero duty below the minimum");
`endif

endmodule
